### hdl/e2r_pkg.sv
`timescale 1ns / 1ps
package e2r_pkg;
	localparam int ANG_W = 16;
	localparam int OUT_W = 16;
	localparam int STEPS = 24;
	localparam int CW = 33;
	localparam int ZW = 33;
	localparam logic signed [CW-1:0] X_INIT = 33'sd652032874;
	localparam logic signed [CW-1:0] Q30_ONE = 33'sd1073741824;

	typedef logic signed [CW-1:0] cval_t;
	typedef logic signed [ZW-1:0] zval_t;

	typedef struct packed {
		cval_t x;
		cval_t y;
		zval_t z;
		logic [1:0] k;
	} cstate_t;

	typedef struct packed {
		cstate_t r;
		cstate_t p;
		cstate_t w;
	} ctrio_t;

	function automatic zval_t atan_lut(input logic [4:0] i);
		zval_t v;
		begin
			unique case (i)
				5'd0: v = 33'sd536870912;
				5'd1: v = 33'sd316933406;
				5'd2: v = 33'sd167458907;
				5'd3: v = 33'sd85004756;
				5'd4: v = 33'sd42667331;
				5'd5: v = 33'sd21354465;
				5'd6: v = 33'sd10679838;
				5'd7: v = 33'sd5340245;
				5'd8: v = 33'sd2670163;
				5'd9: v = 33'sd1335087;
				5'd10: v = 33'sd667544;
				5'd11: v = 33'sd333772;
				5'd12: v = 33'sd166886;
				5'd13: v = 33'sd83443;
				5'd14: v = 33'sd41722;
				5'd15: v = 33'sd20861;
				5'd16: v = 33'sd10430;
				5'd17: v = 33'sd5215;
				5'd18: v = 33'sd2608;
				5'd19: v = 33'sd1304;
				5'd20: v = 33'sd652;
				5'd21: v = 33'sd326;
				5'd22: v = 33'sd163;
				5'd23: v = 33'sd81;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

	function automatic cstate_t cstart(input logic [ANG_W-1:0] a);
		cstate_t s;
		logic [31:0] u;
		logic [31:0] d;
		begin
			u = {a, 16'h0000};
			s.k = 2'((u + 32'h2000_0000) >> 30);
			d = u - {s.k, 30'd0};
			s.z = ZW'(signed'(d));
			s.x = X_INIT;
			s.y = '0;
			return s;
		end
	endfunction
endpackage

### hdl/e2r_if.sv
`timescale 1ns / 1ps
interface e2r_if #(parameter int W = 48);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### hdl/e2r_cell.sv
`timescale 1ns / 1ps
module e2r_cell import e2r_pkg::*; #(
	parameter int STEP = 0
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vin,
	input ctrio_t din,
	output logic vout,
	output ctrio_t dout
);
	function automatic cstate_t rot(input cstate_t s);
		cstate_t o;
		cval_t dx;
		cval_t dy;
		begin
			dx = s.y >>> STEP;
			dy = s.x >>> STEP;
			o = s;
			if (!s.z[ZW-1]) begin
				o.x = s.x - dx;
				o.y = s.y + dy;
				o.z = s.z - atan_lut(5'(STEP));
			end else begin
				o.x = s.x + dx;
				o.y = s.y - dy;
				o.z = s.z + atan_lut(5'(STEP));
			end
			return o;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout.r <= rot(din.r);
			dout.p <= rot(din.p);
			dout.w <= rot(din.w);
		end
	end
endmodule

### hdl/e2r_mix.sv
`timescale 1ns / 1ps
module e2r_mix import e2r_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vin,
	input ctrio_t din,
	output logic vout,
	output logic [9*OUT_W-1:0] dout
);
	localparam int SH = 60 - FRAC_BITS;
	localparam logic signed [67:0] LIM = 68'sd1 <<< FRAC_BITS;
	localparam logic signed [67:0] HALF = 68'sd1 <<< (SH - 1);

	typedef logic signed [31:0] u_t;
	typedef logic signed [63:0] p_t;

	function automatic u_t fin(input cval_t x, input cval_t y, input logic [1:0] k,
			input logic want_sin);
		cval_t c;
		cval_t s;
		cval_t r;
		begin
			c = (x > Q30_ONE) ? Q30_ONE : ((x < -Q30_ONE) ? -Q30_ONE : x);
			s = (y > Q30_ONE) ? Q30_ONE : ((y < -Q30_ONE) ? -Q30_ONE : y);
			unique case (k)
				2'd0: r = want_sin ? s : c;
				2'd1: r = want_sin ? c : -s;
				2'd2: r = want_sin ? -s : -c;
				default: r = want_sin ? -c : s;
			endcase
			return u_t'(r);
		end
	endfunction

	function automatic logic [OUT_W-1:0] to_out(input logic signed [67:0] q);
		logic signed [67:0] v;
		begin
			v = (q + HALF) >>> SH;
			if (v > LIM) v = LIM;
			if (v < -LIM) v = -LIM;
			return v[OUT_W-1:0];
		end
	endfunction

	u_t sr_s1, cr_s1, sp_s1, cp_s1, sy_s1, cy_s1;
	logic v_s1, v_s2, v_s3, v_s4;
	u_t sr_s2, cr_s2, sp_s2, cp_s2, sy_s2, cy_s2;
	p_t cysp_s2, sysp_s2;
	u_t a_s3, b_s3, sr_s3, cr_s3, sy_s3, cy_s3, sp_s3;
	p_t cp_cy_s3, cp_sy_s3, cpsr_s3, cpcr_s3;
	p_t t1_s3, t2_s3, t4_s3, t5_s3;
	p_t u1_s3, u2_s3, u4_s3, u5_s3;
	logic signed [67:0] e_s4 [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s1 <= fin(din.r.x, din.r.y, din.r.k, 1'b1);
			cr_s1 <= fin(din.r.x, din.r.y, din.r.k, 1'b0);
			sp_s1 <= fin(din.p.x, din.p.y, din.p.k, 1'b1);
			cp_s1 <= fin(din.p.x, din.p.y, din.p.k, 1'b0);
			sy_s1 <= fin(din.w.x, din.w.y, din.w.k, 1'b1);
			cy_s1 <= fin(din.w.x, din.w.y, din.w.k, 1'b0);

			cysp_s2 <= p_t'(cy_s1) * p_t'(sp_s1);
			sysp_s2 <= p_t'(sy_s1) * p_t'(sp_s1);
			sr_s2 <= sr_s1;
			cr_s2 <= cr_s1;
			sp_s2 <= sp_s1;
			cp_s2 <= cp_s1;
			sy_s2 <= sy_s1;
			cy_s2 <= cy_s1;

			a_s3 <= u_t'(cysp_s2 >>> 30);
			b_s3 <= u_t'(sysp_s2 >>> 30);
			cp_cy_s3 <= p_t'(cy_s2) * p_t'(cp_s2);
			cp_sy_s3 <= p_t'(sy_s2) * p_t'(cp_s2);
			cpsr_s3 <= p_t'(cp_s2) * p_t'(sr_s2);
			cpcr_s3 <= p_t'(cp_s2) * p_t'(cr_s2);
			u1_s3 <= p_t'(sy_s2) * p_t'(cr_s2);
			u2_s3 <= p_t'(sy_s2) * p_t'(sr_s2);
			u4_s3 <= p_t'(cy_s2) * p_t'(cr_s2);
			u5_s3 <= p_t'(cy_s2) * p_t'(sr_s2);
			sr_s3 <= sr_s2;
			cr_s3 <= cr_s2;
			sy_s3 <= sy_s2;
			cy_s3 <= cy_s2;
			sp_s3 <= sp_s2;

			e_s4[0] <= 68'(cp_cy_s3);
			e_s4[1] <= 68'(t1_s3) - 68'(u1_s3);
			e_s4[2] <= 68'(t2_s3) + 68'(u2_s3);
			e_s4[3] <= 68'(cp_sy_s3);
			e_s4[4] <= 68'(t4_s3) + 68'(u4_s3);
			e_s4[5] <= 68'(t5_s3) - 68'(u5_s3);
			e_s4[6] <= -(68'(sp_s3) <<< 30);
			e_s4[7] <= 68'(cpsr_s3);
			e_s4[8] <= 68'(cpcr_s3);
		end
	end

	assign t1_s3 = p_t'(a_s3) * p_t'(sr_s3);
	assign t2_s3 = p_t'(a_s3) * p_t'(cr_s3);
	assign t4_s3 = p_t'(b_s3) * p_t'(sr_s3);
	assign t5_s3 = p_t'(b_s3) * p_t'(cr_s3);

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			dout[i*OUT_W +: OUT_W] = to_out(e_s4[i]);
		end
	end

	assign vout = v_s4;
endmodule

### hdl/euler_to_rotation_matrix.sv
`timescale 1ns / 1ps
// Pipeline: 24 rotation cells, then 4 mix stages, from input transfer to result.
// Throughput: one angle triple per cycle; the pipeline advances whenever the output
// register is empty or being drained, so a stall at the sink holds the whole chain.
// Reset: arst_n clears all valid flags; payload registers are not reset.
module euler_to_rotation_matrix import e2r_pkg::*; #(
	parameter int FRAC_BITS = 14
) (
	input logic clk,
	input logic arst_n,
	e2r_if.sink in_ch,
	e2r_if.source out_ch
);
	logic en;
	logic vld [STEPS+1];
	ctrio_t dat [STEPS+1];
	logic mix_v;
	logic [9*OUT_W-1:0] mix_d;

	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	assign vld[0] = in_ch.valid;
	assign dat[0].r = cstart(in_ch.data[ANG_W-1:0]);
	assign dat[0].p = cstart(in_ch.data[2*ANG_W-1:ANG_W]);
	assign dat[0].w = cstart(in_ch.data[3*ANG_W-1:2*ANG_W]);

	for (genvar g = 0; g < STEPS; g++) begin : g_cell
		e2r_cell #(.STEP(g)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.vin(vld[g]),
			.din(dat[g]),
			.vout(vld[g+1]),
			.dout(dat[g+1])
		);
	end

	e2r_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vin(vld[STEPS]),
		.din(dat[STEPS]),
		.vout(mix_v),
		.dout(mix_d)
	);

	assign out_ch.valid = mix_v;
	assign out_ch.data = mix_d;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld[1]))
		else $error("cell valid moved during stall");
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> (vld[1] == $past(in_ch.valid)))
		else $error("first cell valid mismatch");
	a_m20: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.data[6*OUT_W +: OUT_W] != 16'h8000))
		else $error("m20 beyond saturation");
endmodule
